FILE: sv/rlmf_pkg.sv
// Shared constants, types and the window test for the raster local minimum finder.
`timescale 1ns / 1ps

package rlmf_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WIDTH_W    = COL_W + 1;
    localparam int ROW_W      = 16;
    localparam int ELEV_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int NUM_CAND   = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_RASTER_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RASTER_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NO_DATA_VALUE = 2'd2;

    // Candidate slots, in raster order of the pixels they test.
    localparam int CAND_UP_LEFT = 0;
    localparam int CAND_UP      = 1;
    localparam int CAND_LEFT    = 2;
    localparam int CAND_HERE    = 3;

    typedef logic signed [ELEV_W-1:0] elev_t;

    // Window [row][col], row 2 and col 2 are the newest.
    typedef logic [2:0][2:0][ELEV_W-1:0] window_t;

    typedef struct packed {
        elev_t older;
        elev_t newer;
    } line_t;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        elev_t            sample;
        logic             eol;
        logic             last;
    } pix_t;

    typedef struct packed {
        logic [NUM_CAND-1:0]             hit;
        logic [NUM_CAND-1:0][ELEV_W-1:0] elev;
        logic [COL_W-1:0]                col;
        logic [ROW_W-1:0]                row;
    } cand_t;

    // True when window position (cx, ry) holds a minimum among its valid neighbors.
    function automatic logic judge(window_t win, int cx, int ry, logic [2:0] colok,
                                   logic [2:0] rowok, elev_t nodata);
        elev_t v;
        elev_t w;
        logic  ok;
        int    x;
        int    y;
        v  = $signed(win[ry][cx]);
        ok = (v != nodata);
        for (int dy = -1; dy <= 1; dy++) begin
            for (int dx = -1; dx <= 1; dx++) begin
                x = cx + dx;
                y = ry + dy;
                if (!(dx == 0 && dy == 0) && x >= 0 && x <= 2 && y >= 0 && y <= 2) begin
                    if (colok[x] && rowok[y]) begin
                        w = $signed(win[y][x]);
                        if (w != nodata && w < v) begin
                            ok = 1'b0;
                        end
                    end
                end
            end
        end
        return ok;
    endfunction

endpackage

FILE: sv/rlmf_if.sv
// Channel interfaces of the raster local minimum finder.
`timescale 1ns / 1ps

interface rlmf_sample_if
    import rlmf_pkg::*;
();
    logic  valid;
    logic  ready;
    elev_t elevation_sample;

    modport source (output valid, output elevation_sample, input ready);
    modport sink (input valid, input elevation_sample, output ready);
endinterface

interface rlmf_minimum_if
    import rlmf_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [COL_W-1:0] minimum_col;
    logic [ROW_W-1:0] minimum_row;
    elev_t            minimum_elevation;
    logic             last_of_run;

    modport source (output valid, output minimum_col, output minimum_row,
                    output minimum_elevation, output last_of_run, input ready);
    modport sink (input valid, input minimum_col, input minimum_row,
                  input minimum_elevation, input last_of_run, output ready);
endinterface

interface rlmf_cfg_if
    import rlmf_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: sv/rlmf_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module rlmf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: sv/rlmf_window.sv
// 3x3 window registers and the four minimum tests made per pixel.
`timescale 1ns / 1ps

module rlmf_window
    import rlmf_pkg::*;
(
    input  logic  clk,
    input  logic  advance,
    input  pix_t  pix,
    input  line_t line_rd,
    input  elev_t nodata,
    output cand_t cand
);

    // Window columns 1 and 2 as left by the previous pixel.
    elev_t   col1_reg [3];
    elev_t   col2_reg [3];
    window_t win;
    logic [2:0] colok;
    logic [2:0] rowok;
    logic    c_ge1;
    logic    r_ge1;

    always_comb
    begin
        for (int y = 0; y < 3; y++)
        begin
            win[y][0] = col1_reg[y];
            win[y][1] = col2_reg[y];
        end
        win[0][2] = line_rd.older;
        win[1][2] = line_rd.newer;
        win[2][2] = pix.sample;
    end

    assign c_ge1 = (pix.col != '0);
    assign r_ge1 = (pix.row != '0);
    assign colok = {1'b1, c_ge1, (pix.col[COL_W-1:1] != '0)};
    assign rowok = {1'b1, r_ge1, (pix.row[ROW_W-1:1] != '0)};

    always_comb
    begin
        cand.col = pix.col;
        cand.row = pix.row;
        cand.elev[CAND_UP_LEFT] = win[1][1];
        cand.elev[CAND_UP]      = win[1][2];
        cand.elev[CAND_LEFT]    = win[2][1];
        cand.elev[CAND_HERE]    = win[2][2];
        cand.hit[CAND_UP_LEFT]  = r_ge1 && c_ge1 && judge(win, 1, 1, colok, rowok, nodata);
        cand.hit[CAND_UP]       = r_ge1 && pix.eol && judge(win, 2, 1, colok, rowok, nodata);
        cand.hit[CAND_LEFT]     = pix.last && c_ge1 && judge(win, 1, 2, colok, rowok, nodata);
        cand.hit[CAND_HERE]     = pix.last && pix.eol && judge(win, 2, 2, colok, rowok, nodata);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int y = 0; y < 3; y++)
            begin
                col1_reg[y] <= col2_reg[y];
                col2_reg[y] <= $signed(win[y][2]);
            end
        end
    end

endmodule

FILE: sv/rlmf_emit.sv
// Result register for one pixel's minima; one item per cycle while ready is high.
`timescale 1ns / 1ps

module rlmf_emit
    import rlmf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  load,
    input  cand_t cand,
    output logic  free,
    rlmf_minimum_if.source minima
);

    logic [NUM_CAND-1:0]             hit_reg;
    logic [NUM_CAND-1:0][ELEV_W-1:0] elev_reg;
    logic [COL_W-1:0]                col_reg;
    logic [ROW_W-1:0]                row_reg;
    logic [1:0]                      sel;
    logic [NUM_CAND-1:0]             sel_oh;
    logic [NUM_CAND-1:0]             hit_next;
    logic                            found;
    logic                            fire;

    always_comb
    begin
        sel   = '0;
        found = 1'b0;
        for (int i = 0; i < NUM_CAND; i++)
        begin
            if (hit_reg[i] && !found)
            begin
                sel   = 2'(i);
                found = 1'b1;
            end
        end
    end

    assign sel_oh   = NUM_CAND'(1) << sel;
    assign fire     = minima.valid && minima.ready;
    assign hit_next = fire ? (hit_reg & ~sel_oh) : hit_reg;
    assign free     = (hit_next == '0);

    assign minima.valid             = (hit_reg != '0);
    assign minima.minimum_elevation = $signed(elev_reg[sel]);
    assign minima.last_of_run       = ((hit_reg & ~sel_oh) == '0);
    // Slots for the left neighbor column sit one column back, upper slots one row back.
    assign minima.minimum_col = (sel == 2'(CAND_UP_LEFT) || sel == 2'(CAND_LEFT)) ?
                                col_reg - COL_W'(1) : col_reg;
    assign minima.minimum_row = (sel == 2'(CAND_UP_LEFT) || sel == 2'(CAND_UP)) ?
                                row_reg - ROW_W'(1) : row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= '0;
        end
        else if (load)
        begin
            hit_reg <= cand.hit;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            elev_reg <= cand.elev;
            col_reg  <= cand.col;
            row_reg  <= cand.row;
        end
    end

endmodule

FILE: sv/raster_local_minimum_finder.sv
// Top level of the raster local minimum finder.
// Elevation samples enter on the samples channel in row-major order, one item per
// accepted handshake. Each minimum found leaves on the minima channel as one item
// with its column, row and elevation; last_of_run marks the final item released by
// a given sample. A pixel is decided when its last neighbor arrives, so most
// results come one row and one column late; row ends, the last row and the
// frame end release up to four items for one sample.
// Path: a sample is registered together with its line store read, then the window
// is tested and its results load into the result register once that is free.
// Throughput: one sample per cycle while the receiver is ready and each sample
// releases at most one result; more results from one sample hold back later ones.
// The cfg channel is always ready; writing the width or height restarts the frame.
// Configure only while the block is idle.
// Reset clears the row and column counters, all pending items, and loads width
// 4096, height 1 and no-data code -9999. The line stores are not cleared.
// When the receiver stalls, results hold and samples.ready drops once the input
// and result registers are both full.
`timescale 1ns / 1ps

module raster_local_minimum_finder
    import rlmf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    rlmf_sample_if.sink    samples,
    rlmf_minimum_if.source minima,
    rlmf_cfg_if.sink       cfg
);

    logic [WIDTH_W-1:0] width_reg;
    logic [ROW_W-1:0]   height_reg;
    elev_t              nodata_reg;
    logic [COL_W-1:0]   col_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [WIDTH_W-1:0] w_eff;
    logic [ROW_W-1:0]   h_eff;
    logic [COL_W-1:0]   c_cur;
    logic [ROW_W-1:0]   r_cur;
    logic               eol;
    logic               last;
    logic               accept;
    logic               cfg_fire;
    logic               s1_valid_reg;
    pix_t               s1_pix_reg;
    logic               s1_advance;
    logic               emit_free;
    logic [2*ELEV_W-1:0] ram_rdata;
    line_t              line_rd;
    line_t              line_wr;
    logic               fwd_reg;
    line_t              fwd_data_reg;
    cand_t              cand;

    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = WIDTH_W'(1);
        end
        else if (width_reg > WIDTH_W'(MAX_WIDTH))
        begin
            w_eff = WIDTH_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = width_reg;
        end
    end

    assign h_eff = (height_reg == '0) ? ROW_W'(1) : height_reg;
    assign c_cur = ({1'b0, col_reg} >= w_eff) ? '0 : col_reg;
    assign r_cur = (row_reg >= h_eff) ? '0 : row_reg;
    assign eol   = ({1'b0, c_cur} == w_eff - WIDTH_W'(1));
    assign last  = (r_cur == h_eff - ROW_W'(1));

    assign s1_advance    = s1_valid_reg && emit_free;
    assign samples.ready = !s1_valid_reg || s1_advance;
    assign accept        = samples.valid && samples.ready;
    assign cfg.ready     = 1'b1;
    assign cfg_fire      = cfg.valid && cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_W'(MAX_WIDTH);
            height_reg <= ROW_W'(1);
            nodata_reg <= -32'sd9999;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else if (cfg_fire)
        begin
            case (cfg.index)
                REG_RASTER_WIDTH:
                begin
                    width_reg <= cfg.data[WIDTH_W-1:0];
                    col_reg   <= '0;
                    row_reg   <= '0;
                end
                REG_RASTER_HEIGHT:
                begin
                    height_reg <= cfg.data[ROW_W-1:0];
                    col_reg    <= '0;
                    row_reg    <= '0;
                end
                REG_NO_DATA_VALUE:
                begin
                    nodata_reg <= $signed(cfg.data[ELEV_W-1:0]);
                end
                default:
                begin
                end
            endcase
        end
        else if (accept)
        begin
            if (eol)
            begin
                col_reg <= '0;
                row_reg <= last ? '0 : r_cur + ROW_W'(1);
            end
            else
            begin
                col_reg <= c_cur + COL_W'(1);
                row_reg <= r_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                // With a one-column raster the pixel ahead writes the entry being read.
                fwd_reg      <= s1_advance && (s1_pix_reg.col == c_cur);
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg.col    <= c_cur;
            s1_pix_reg.row    <= r_cur;
            s1_pix_reg.sample <= samples.elevation_sample;
            s1_pix_reg.eol    <= eol;
            s1_pix_reg.last   <= last;
            fwd_data_reg      <= line_wr;
        end
    end

    assign line_rd       = fwd_reg ? fwd_data_reg : line_t'(ram_rdata);
    assign line_wr.older = line_rd.newer;
    assign line_wr.newer = s1_pix_reg.sample;

    rlmf_ram #(
        .WIDTH (2 * ELEV_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_advance),
        .waddr (s1_pix_reg.col),
        .wdata (line_wr),
        .re    (accept),
        .raddr (c_cur),
        .rdata (ram_rdata)
    );

    rlmf_window u_window (
        .clk     (clk),
        .advance (s1_advance),
        .pix     (s1_pix_reg),
        .line_rd (line_rd),
        .nodata  (nodata_reg),
        .cand    (cand)
    );

    rlmf_emit u_emit (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (s1_advance),
        .cand   (cand),
        .free   (emit_free),
        .minima (minima)
    );

endmodule
